// ===== hdl/lbs_pkg.sv =====
`default_nettype none

package lbs_pkg;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_CONTAINS = 3'd2,
      OP_REWIND   = 3'd3,
      OP_READ     = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] index;
      logic [16:0] count;
   } req_type;

   typedef struct packed {
      logic        member;
      logic [16:0] next_index;
      logic [7:0]  byte_value;
      logic        last;
   } rsp_type;

   // The mark never passes 2^16 leaves, so no more than 8192 bytes are ever written.
   localparam logic [16:0] MARK_MAX       = 17'h10000;
   localparam int          MAX_MARK_BYTES = 8192;

endpackage

`default_nettype wire

// ===== hdl/lbs_ram.sv =====
`default_nettype none

module lbs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 8192,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/lbs_seq.sv =====
`default_nettype none

module lbs_seq #(
   parameter  int LEAF_CAPACITY  = 65536,
   parameter  int MAX_READ_BYTES = 64,
   localparam int MemDepth = (((LEAF_CAPACITY + 7) / 8) < lbs_pkg::MAX_MARK_BYTES) ?
                             ((LEAF_CAPACITY + 7) / 8) : lbs_pkg::MAX_MARK_BYTES,
   localparam int AW       = (MemDepth > 1) ? $clog2(MemDepth) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lbs_pkg::req_type req_item,
   output logic                  rsp_valid,
   output lbs_pkg::rsp_type      rsp_item,
   output logic                  ram_we,
   output logic [AW-1:0]         ram_waddr,
   output logic [7:0]            ram_wdata,
   output logic [AW-1:0]         ram_raddr,
   input  wire logic [7:0]       ram_rdata
);

   import lbs_pkg::*;

   localparam int KW = (MAX_READ_BYTES > 1) ? $clog2(MAX_READ_BYTES) : 1;
   localparam int NW = $clog2(MAX_READ_BYTES + 1);
   localparam logic [16:0] LIM = (LEAF_CAPACITY < 65536) ? 17'(LEAF_CAPACITY) : MARK_MAX;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_BIT,
      S_RW_FIRST,
      S_RW_ZERO,
      S_RD_ISSUE
   } state_type;

   state_type     state_ff,  state_in;
   req_type       req_ff,    req_in;
   logic [16:0]   hw_ff,     hw_in;
   logic [AW-1:0] ptr_ff,    ptr_in;
   logic [AW-1:0] end_ff,    end_in;
   logic [16:0]   cnt_ff,    cnt_in;
   logic [KW-1:0] k_ff,      k_in;
   logic [KW-1:0] klast_ff,  klast_in;
   logic          p_ff,      p_in;
   logic          p_ok_ff,   p_ok_in;
   logic          p_last_ff, p_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff,    rsp_in;

   logic          accept;
   logic [16:0]   cnt_sat;
   logic [16:0]   hw_m1;
   logic [NW-1:0] n_req;
   logic [16:0]   rd_byte;
   logic          rd_ok;
   logic [7:0]    bit_mask;
   logic          in_cap;

   function automatic rsp_type single_rsp(input logic [16:0] mark, input logic member);
      rsp_type r;
      r.member     = member;
      r.next_index = mark;
      r.byte_value = 8'd0;
      r.last       = 1'b1;
      return r;
   endfunction

   assign busy    = (state_ff != S_IDLE) || p_ff;
   assign accept  = start && !busy;
   assign cnt_sat = (req_item.count > LIM) ? LIM : req_item.count;
   assign hw_m1   = hw_ff - 17'd1;
   assign n_req   = (req_item.count > 17'(MAX_READ_BYTES)) ? NW'(MAX_READ_BYTES) :
                                                             NW'(req_item.count);
   assign rd_byte  = {1'b0, req_ff.index} + 17'(k_ff);
   assign rd_ok    = rd_byte < 17'(MemDepth);
   assign bit_mask = 8'h80 >> req_ff.index[2:0];
   assign in_cap   = {1'b0, req_ff.index} < LIM;

   // Read port: single-bit ops and a partial first rewind byte are looked up
   // in the same cycle that the item is accepted.
   always_comb begin
      ram_raddr = ptr_ff;
      if (state_ff == S_IDLE) begin
         if (req_item.op == OP_REWIND) begin
            ram_raddr = AW'(cnt_sat[16:3]);
         end else begin
            ram_raddr = AW'(req_item.index[15:3]);
         end
      end else if (state_ff == S_RD_ISSUE) begin
         ram_raddr = AW'(rd_byte);
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = 8'd0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
         end
         S_BIT: begin
            ram_we    = in_cap && (req_ff.op == OP_ADD || req_ff.op == OP_REMOVE);
            ram_waddr = AW'(req_ff.index[15:3]);
            ram_wdata = (req_ff.op == OP_ADD) ? (ram_rdata | bit_mask) :
                                                (ram_rdata & ~bit_mask);
         end
         S_RW_FIRST: begin
            // Leaves below the new count keep their bits.
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(8'hff >> cnt_ff[2:0]);
         end
         S_RW_ZERO: begin
            // Bits at or above the mark are always clear, so whole bytes go to zero.
            ram_we = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      hw_in        = hw_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      klast_in     = klast_ff;
      p_in         = 1'b0;
      p_ok_in      = rd_ok;
      p_last_in    = (k_ff == klast_ff);
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (p_ff) begin
         rsp_valid_in      = 1'b1;
         rsp_in.member     = 1'b0;
         rsp_in.next_index = hw_ff;
         rsp_in.byte_value = p_ok_ff ? ram_rdata : 8'd0;
         rsp_in.last       = p_last_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == AW'(MemDepth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in = req_item;
               case (req_item.op) inside
                  OP_ADD, OP_REMOVE, OP_CONTAINS: begin
                     state_in = S_BIT;
                  end
                  OP_REWIND: begin
                     cnt_in = cnt_sat;
                     if (cnt_sat < hw_ff) begin
                        ptr_in   = AW'(cnt_sat[16:3]);
                        end_in   = AW'(hw_m1[16:3]);
                        state_in = (cnt_sat[2:0] != 3'd0) ? S_RW_FIRST : S_RW_ZERO;
                     end else begin
                        hw_in        = cnt_sat;
                        rsp_valid_in = 1'b1;
                        rsp_in       = single_rsp(cnt_sat, 1'b0);
                     end
                  end
                  OP_READ: begin
                     if (n_req != '0) begin
                        k_in     = '0;
                        klast_in = KW'(n_req - 1'b1);
                        state_in = S_RD_ISSUE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = single_rsp(hw_ff, 1'b0);
                  end
               endcase
            end
         end
         S_BIT: begin
            if (req_ff.op == OP_ADD && in_cap && {1'b0, req_ff.index} >= hw_ff) begin
               hw_in = {1'b0, req_ff.index} + 17'd1;
            end
            rsp_valid_in = 1'b1;
            rsp_in = single_rsp(hw_in, in_cap && req_ff.op == OP_CONTAINS &&
                                       ((ram_rdata & bit_mask) != 8'd0));
            state_in = S_IDLE;
         end
         S_RW_FIRST, S_RW_ZERO: begin
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == end_ff) begin
               hw_in        = cnt_ff;
               rsp_valid_in = 1'b1;
               rsp_in       = single_rsp(cnt_ff, 1'b0);
               state_in     = S_IDLE;
            end else begin
               state_in = S_RW_ZERO;
            end
         end
         S_RD_ISSUE: begin
            p_in = 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff == klast_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         hw_ff        <= '0;
         p_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         hw_ff        <= hw_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      end_ff    <= end_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      klast_ff  <= klast_in;
      p_ok_ff   <= p_ok_in;
      p_last_ff <= p_last_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      hw_ff <= LIM)
      else $error("high-water mark beyond leaf limit");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_we)
      else $error("store written while idle");

   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |=> rsp_valid_ff)
      else $error("read burst has a gap before its last byte");

   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.op == OP_READ && req_item.count == 17'd0 |=> !busy && !rsp_valid_ff)
      else $error("zero-length read produced work");

endmodule

`default_nettype wire

// ===== hdl/leaf_bitmap_set_with_rewind_top.sv =====
// Channel   Ports                      Direction  Transfer
// request   start, busy, req_item      in         start high and busy low at a clock edge
// response  rsp_valid, rsp_item        out        rsp_valid high at a clock edge, no back-pressure
//
// After reset a clearing pass zeroes the byte store of min(ceil(LEAF_CAPACITY/8), 8192) bytes,
// one byte a cycle (8192 bytes at the default); busy stays high meanwhile.
// Add, remove and contains read the store; then add and remove modify the byte and write it back.
// Rewind clears the leaves from the new count up to the old mark, a store byte at a time; a rewind that clears
// nothing and an unknown op answer in the cycle after acceptance.
// Read bytes streams one byte per cycle from the store read port; busy drops in the same
// cycle that the last byte appears on the response. The receiver cannot stall, so results never wait.
`default_nettype none

module leaf_bitmap_set_with_rewind_top #(
   parameter  int LEAF_CAPACITY  = 65536,
   parameter  int MAX_READ_BYTES = 64,
   localparam int MemDepth = (((LEAF_CAPACITY + 7) / 8) < lbs_pkg::MAX_MARK_BYTES) ?
                             ((LEAF_CAPACITY + 7) / 8) : lbs_pkg::MAX_MARK_BYTES,
   localparam int AW       = (MemDepth > 1) ? $clog2(MemDepth) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lbs_pkg::req_type req_item,
   output logic                  rsp_valid,
   output lbs_pkg::rsp_type      rsp_item
);

   import lbs_pkg::*;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   lbs_ram #(
      .WIDTH (8),
      .DEPTH (MemDepth)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lbs_seq #(
      .LEAF_CAPACITY  (LEAF_CAPACITY),
      .MAX_READ_BYTES (MAX_READ_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lbs_pkg::*;

   localparam int STORE_BYTES    = 8192;
   localparam int READ_MAX       = 64;
   localparam int RANDOM_ITEMS   = 76;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int TAIL_CYCLES    = 20;

   localparam logic [2:0]  OP_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0]  OP_UNKNOWN_LAST  = 3'd7;
   localparam logic [16:0] COUNT_ALL_ONES   = 17'h1ffff;

   typedef struct {
      req_type rq;
      bit      drain;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   leaf_bitmap_set_with_rewind_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected behavior of the bitmap and its high-water mark.
   logic [7:0]  leaf_bytes [0:STORE_BYTES-1];
   logic [16:0] leaf_mark;
   rsp_type     expected_rsp [$];
   pending_type pending_q [$];
   pending_type next_pending;

   int error_count     = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int rewinds_seen    = 0;
   int reads_seen      = 0;
   int planned_items   = 0;
   int burst_left      = 1;
   int gap_left        = 0;
   int idle_cycles     = 0;
   logic [16:0] top_mark = '0;

   function automatic void predict_bitmap(input req_type rq);
      rsp_type     r;
      logic [16:0] new_count;
      int unsigned n;
      int unsigned b;
      r = '0;
      case (rq.op)
         OP_ADD: begin
            leaf_bytes[rq.index >> 3][3'd7 - rq.index[2:0]] = 1'b1;
            if ({1'b0, rq.index} >= leaf_mark) leaf_mark = {1'b0, rq.index} + 17'd1;
         end
         OP_REMOVE: begin
            leaf_bytes[rq.index >> 3][3'd7 - rq.index[2:0]] = 1'b0;
         end
         OP_CONTAINS: begin
            r.member = leaf_bytes[rq.index >> 3][3'd7 - rq.index[2:0]];
         end
         OP_REWIND: begin
            new_count = (rq.count > MARK_MAX) ? MARK_MAX : rq.count;
            for (int unsigned i = new_count; i < leaf_mark; i++)
               leaf_bytes[i >> 3][7 - (i & 7)] = 1'b0;
            leaf_mark = new_count;
         end
         OP_READ: begin
            n = (rq.count > READ_MAX) ? READ_MAX : rq.count;
            for (int unsigned k = 0; k < n; k++) begin
               b = rq.index + k;
               r.next_index = leaf_mark;
               r.byte_value = (b < STORE_BYTES) ? leaf_bytes[b] : 8'h00;
               r.last       = (k + 1 == n);
               expected_rsp.push_back(r);
            end
         end
         default: ;
      endcase
      if (rq.op != OP_READ) begin
         r.next_index = leaf_mark;
         r.last       = 1'b1;
         expected_rsp.push_back(r);
      end
      if (leaf_mark > top_mark) top_mark = leaf_mark;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic void queue_item(input logic [2:0] op, input logic [15:0] index,
                                      input logic [16:0] count);
      pending_type p;
      p.rq.op    = op;
      p.rq.index = index;
      p.rq.count = count;
      p.drain    = 1'b0;
      pending_q.push_back(p);
      planned_items++;
   endfunction

   function automatic void queue_drain();
      pending_type p;
      p.rq    = '0;
      p.drain = 1'b1;
      pending_q.push_back(p);
   endfunction

   // Sender: bursts of items separated by random gaps. A drain marker holds the
   // next item back until every expected result has come.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
      end else begin
         if (start && !busy) begin
            predict_bitmap(req_item);
            items_accepted++;
            if (req_item.op == OP_REWIND) rewinds_seen++;
            if (req_item.op == OP_READ) reads_seen++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_q.size() > 0 && pending_q[0].drain) begin
               if (expected_rsp.size() == 0) next_pending = pending_q.pop_front();
               start <= 1'b0;
            end else if (pending_q.size() > 0) begin
               next_pending = pending_q.pop_front();
               req_item <= next_pending.rq;
               start    <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Receiver: results cannot be held off, so every strobe is checked.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("result arrived with no item waiting for it");
         end else begin
            want = expected_rsp.pop_front();
            check_field("member", int'(rsp_item.member), int'(want.member));
            check_field("next_index", int'(rsp_item.next_index), int'(want.next_index));
            check_field("byte_value", int'(rsp_item.byte_value), int'(want.byte_value));
            check_field("last", int'(rsp_item.last), int'(want.last));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int base;
      int random_items;
      for (int i = 0; i < STORE_BYTES; i++) leaf_bytes[i] = 8'h00;
      leaf_mark    = '0;
      random_items = 0;

      // Directed part: field extremes, every op, and the corner cases.
      queue_item(OP_ADD, 16'd0, 17'd0);
      queue_item(OP_ADD, 16'd7, 17'd0);
      queue_item(OP_ADD, 16'd8, 17'd0);
      queue_item(OP_ADD, 16'hffff, COUNT_ALL_ONES);
      queue_item(OP_CONTAINS, 16'hffff, 17'd0);
      queue_item(OP_CONTAINS, 16'd1, 17'd0);
      queue_item(OP_REMOVE, 16'd7, 17'd0);
      queue_item(OP_CONTAINS, 16'd7, 17'd0);
      queue_item(OP_READ, 16'd0, 17'd2);
      // A read of zero bytes answers nothing at all.
      queue_item(OP_READ, 16'd0, 17'd0);
      // Over-long read that also runs off the end of the store.
      queue_item(OP_READ, 16'd8160, 17'd100);
      queue_item(OP_READ, 16'hffff, COUNT_ALL_ONES);
      // Oversized rewind count saturates at the full mark and clears nothing.
      queue_item(OP_REWIND, 16'hffff, COUNT_ALL_ONES);
      queue_drain();
      queue_item(OP_REWIND, 16'd0, 17'd4);
      queue_item(OP_CONTAINS, 16'd0, 17'd0);
      queue_item(OP_CONTAINS, 16'hffff, 17'd0);
      queue_item(OP_READ, 16'd0, 17'd1);
      for (int u = OP_UNKNOWN_FIRST; u <= OP_UNKNOWN_LAST; u++)
         queue_item(3'(u), 16'hffff, COUNT_ALL_ONES);
      // A rewind above the mark raises it.
      queue_item(OP_REWIND, 16'd0, 17'd100);
      queue_item(OP_ADD, 16'd3, 17'd0);
      queue_item(OP_REWIND, 16'd0, 17'd0);
      queue_item(OP_READ, 16'd0, 17'd1);

      // Random part: mostly add/contains/remove/read/rewind sequences, each on a small
      // window of leaves, with some fully random items mixed in.
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_item(3'($urandom_range(OP_ADD, OP_UNKNOWN_LAST)),
                       16'($urandom_range(0, 65535)),
                       17'($urandom_range(0, 1) ? $urandom_range(0, 70)
                                                : $urandom_range(0, COUNT_ALL_ONES)));
            random_items++;
         end else begin
            base = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535 - 64)
                                               : $urandom_range(0, 511);
            repeat ($urandom_range(2, 6)) begin
               queue_item(OP_ADD, 16'(base + $urandom_range(0, 63)), 17'd0);
               random_items++;
            end
            repeat (2) begin
               queue_item(OP_CONTAINS, 16'(base + $urandom_range(0, 63)), 17'd0);
               random_items++;
            end
            queue_item(OP_REMOVE, 16'(base + $urandom_range(0, 63)), 17'd0);
            queue_item(OP_READ, 16'(base >> 3), 17'($urandom_range(1, 9)));
            random_items += 2;
            if ($urandom_range(0, 1)) begin
               queue_item(OP_REWIND, 16'd0, 17'(base + $urandom_range(0, 70)));
               random_items++;
            end
         end
         if ($urandom_range(0, 15) == 0) queue_drain();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (items_accepted < planned_items || expected_rsp.size() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_rsp.size() > 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_rsp.size()));
      $display("run covered %0d of %0d items and %0d results checked",
               items_accepted, planned_items, results_checked);
      $display("%0d rewinds, %0d byte reads, highest mark %0d, %0d mismatches",
               rewinds_seen, reads_seen, top_mark, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/lbs_pkg.sv
hdl/lbs_ram.sv
hdl/lbs_seq.sv
hdl/leaf_bitmap_set_with_rewind_top.sv
verif/testbench.sv
